// ===== hw/rtl/bcsd_pkg.sv =====
// Shared types, constants and code tables for the button code sequence detector.
`default_nettype none

package bcsd_pkg;

  localparam int SeqDepthDefault = 6;
  localparam int CntW            = 3;
  localparam int IdleW           = 17;
  localparam int CfgW            = 16;
  localparam int CfgAddrW        = 3;
  localparam int LongestCode     = 6;

  localparam logic [IdleW-1:0] IdleMax      = {IdleW{1'b1}};
  localparam logic [CfgW-1:0]  TimeoutReset = 16'd3000;
  localparam logic [CfgW-1:0]  LockReset    = 16'd12000;

  localparam logic [0:0] RegTimeout = 1'b0;
  localparam logic [0:0] RegLock    = 1'b1;

  localparam logic [1:0] BtnS = 2'd0;
  localparam logic [1:0] BtnO = 2'd1;
  localparam logic [1:0] BtnU = 2'd2;
  localparam logic [1:0] BtnF = 2'd3;

  localparam logic KindPress = 1'b0;

  localparam int GodLen   = 5;
  localparam int ChaosLen = 6;
  localparam int CryoLen  = 4;

  localparam logic [1:0] CodeGod   [GodLen]   = '{BtnO, BtnS, BtnF, BtnU, BtnO};
  localparam logic [1:0] CodeChaos [ChaosLen] = '{BtnU, BtnU, BtnF, BtnS, BtnO, BtnF};
  localparam logic [1:0] CodeCryo  [CryoLen]  = '{BtnF, BtnF, BtnO, BtnS};

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvGod   = 2'd1,
    EvChaos = 2'd2,
    EvCryo  = 2'd3
  } event_e;

  typedef struct packed {
    logic [CfgW-1:0] timeout_ms;
    logic [CfgW-1:0] lock_duration_ms;
  } cfg_t;

  typedef struct packed {
    event_e          event_res;
    logic            god_active;
    logic            lock_active;
    logic [CntW-1:0] seq_count;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bcsd_cfg_regs.sv =====
// APB-style configuration registers for timeout and lockdown duration.
`default_nettype none

module bcsd_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bcsd_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output bcsd_pkg::cfg_t                    cfg_o
);
  import bcsd_pkg::*;

  logic [CfgW-1:0] timeout_q, timeout_d;
  logic [CfgW-1:0] lock_q, lock_d;
  logic            wr_en;
  logic [0:0]      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    timeout_d = timeout_q;
    lock_d    = lock_q;
    if (wr_en) begin
      case (reg_sel)
        RegTimeout: timeout_d = pwdata[CfgW-1:0];
        RegLock:    lock_d    = pwdata[CfgW-1:0];
        default:    timeout_d = timeout_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegTimeout: prdata = {{(32-CfgW){1'b0}}, timeout_q};
      RegLock:    prdata = {{(32-CfgW){1'b0}}, lock_q};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      lock_q    <= LockReset;
    end else begin
      timeout_q <= timeout_d;
      lock_q    <= lock_d;
    end
  end

  assign cfg_o.timeout_ms       = timeout_q;
  assign cfg_o.lock_duration_ms = lock_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bcsd_core.sv =====
// Sequence store, code matching, idle timer and lockdown countdown.
`default_nettype none

module bcsd_core #(
  parameter int SEQ_DEPTH = bcsd_pkg::SeqDepthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           upd_i,
  input  wire logic           kind_i,
  input  wire logic [1:0]     button_i,
  input  wire bcsd_pkg::cfg_t cfg_i,
  output bcsd_pkg::res_t      res_o
);
  import bcsd_pkg::*;

  localparam int IdxW = $clog2(SEQ_DEPTH);
  localparam logic [CntW:0] DepthC   = (CntW+1)'(SEQ_DEPTH);
  localparam logic [CntW:0] LongestC = (CntW+1)'(LongestCode);

  logic [1:0]       store_q [SEQ_DEPTH];
  logic [CntW-1:0]  count_q, count_d;
  logic [IdleW-1:0] idle_q, idle_d, idle_inc;
  logic             god_q, god_d;
  logic [CfgW-1:0]  lock_q, lock_d;
  logic [CntW-1:0]  cnt_inc;
  logic [IdxW-1:0]  wr_idx;
  logic             wr_en;
  logic             full;
  logic             god_hit, chaos_hit, cryo_hit;
  event_e           ev;

  assign wr_idx   = IdxW'(count_q);
  assign cnt_inc  = count_q + CntW'(1);
  assign full     = ({1'b0, count_q} >= DepthC);
  assign idle_inc = (idle_q == IdleMax) ? idle_q : idle_q + IdleW'(1);

  always_comb begin
    god_hit   = (count_q == CntW'(GodLen - 1)) && (button_i == CodeGod[GodLen-1]);
    chaos_hit = (count_q == CntW'(ChaosLen - 1)) && (button_i == CodeChaos[ChaosLen-1]);
    cryo_hit  = (count_q == CntW'(CryoLen - 1)) && (button_i == CodeCryo[CryoLen-1]);
    for (int i = 0; i < GodLen - 1; i++) begin
      god_hit = god_hit && (store_q[i] == CodeGod[i]);
    end
    for (int i = 0; i < ChaosLen - 1; i++) begin
      chaos_hit = chaos_hit && (store_q[i] == CodeChaos[i]);
    end
    for (int i = 0; i < CryoLen - 1; i++) begin
      cryo_hit = cryo_hit && (store_q[i] == CodeCryo[i]);
    end
  end

  always_comb begin
    count_d = count_q;
    idle_d  = idle_q;
    god_d   = god_q;
    lock_d  = lock_q;
    ev      = EvNone;
    wr_en   = 1'b0;
    if (upd_i) begin
      if (kind_i == KindPress) begin
        if (full) begin
          count_d = '0;
        end else begin
          wr_en  = 1'b1;
          idle_d = '0;
          if (god_hit) begin
            count_d = '0;
            god_d   = 1'b1;
            ev      = EvGod;
          end else if (chaos_hit) begin
            count_d = '0;
            ev      = EvChaos;
          end else if (cryo_hit) begin
            count_d = '0;
            lock_d  = cfg_i.lock_duration_ms;
            ev      = EvCryo;
          end else if ({1'b0, cnt_inc} > LongestC) begin
            count_d = '0;
          end else begin
            count_d = cnt_inc;
          end
        end
      end else begin
        idle_d = idle_inc;
        if ((count_q != '0) && (idle_inc > {{(IdleW-CfgW){1'b0}}, cfg_i.timeout_ms})) begin
          count_d = '0;
        end
        if (lock_q != '0) begin
          lock_d = lock_q - CfgW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= button_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idle_q  <= '0;
      god_q   <= 1'b0;
      lock_q  <= '0;
    end else begin
      count_q <= count_d;
      idle_q  <= idle_d;
      god_q   <= god_d;
      lock_q  <= lock_d;
    end
  end

  assign res_o.event_res   = ev;
  assign res_o.god_active  = god_d;
  assign res_o.lock_active = (lock_d != '0);
  assign res_o.seq_count   = count_d;

endmodule

`default_nettype wire

// ===== hw/rtl/button_code_sequence_detector.sv =====
// Top level of the button code sequence detector with input and result registers.
// The core updates its state from the input register, and each result word is registered.
// Throughput: one word per cycle while the output is not stalled.
// A stalled result register holds the input register, which then raises in_stall_o.
// Reset clears the sequence count, idle timer, god flag and countdown at once and loads
// the timeout and lockdown registers with 3000 and 12000; the symbol store is not cleared.
`default_nettype none

module button_code_sequence_detector #(
  parameter int SEQ_DEPTH = bcsd_pkg::SeqDepthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic [1:0]                    button_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         event_res_o,
  output logic                               god_active_o,
  output logic                               lock_active_o,
  output logic [bcsd_pkg::CntW-1:0]          seq_count_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bcsd_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import bcsd_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       in_valid_q;
  logic       kind_q;
  logic [1:0] button_q;
  logic       out_valid_q;
  res_t       res_q;
  logic       advance;
  logic       in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  bcsd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcsd_core #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (in_valid_q && advance),
    .kind_i   (kind_q),
    .button_i (button_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q   <= kind_i;
      button_q <= button_i;
    end
    if (in_valid_q && advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = res_q.event_res;
  assign god_active_o  = res_q.god_active;
  assign lock_active_o = res_q.lock_active;
  assign seq_count_o   = res_q.seq_count;

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result register could advance");

  a_event_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o != EvNone)) |-> (seq_count_o == '0))
    else $error("code event reported with a nonempty sequence");

  a_god_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == EvGod)) |-> god_active_o)
    else $error("god mode event without the god flag");

  a_cryo_starts_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == EvCryo) && (cfg.lock_duration_ms != '0))
      |-> lock_active_o)
    else $error("cryo lockdown event without an active countdown");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the button code sequence detector.
`timescale 1ns / 100ps

module testbench;
  import bcsd_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int MaxReports = 10;
  localparam int DirRows    = 25;
  localparam int LongBurst  = 120;

  localparam logic KindTick = ~KindPress;
  localparam logic [CfgAddrW-1:0] AddrTimeout = {RegTimeout, 2'b00};
  localparam logic [CfgAddrW-1:0] AddrLock    = {RegLock, 2'b00};

  typedef struct packed {
    logic       kind;
    logic [1:0] btn;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                kind_i        = 1'b0;
  logic [1:0]          button_i      = 2'd0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [1:0]          event_res_o;
  logic                god_active_o;
  logic                lock_active_o;
  logic [CntW-1:0]     seq_count_o;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [CfgAddrW-1:0] paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;

  logic [1:0]       sym_store [SeqDepthDefault];
  logic [CntW-1:0]  sym_cnt     = '0;
  logic [IdleW-1:0] idle_ms     = '0;
  logic             god_flag    = 1'b0;
  logic [CfgW-1:0]  lock_left   = '0;
  logic [CfgW-1:0]  timeout_cfg = TimeoutReset;
  logic [CfgW-1:0]  lock_cfg    = LockReset;

  res_t status_q [$];
  res_t got;
  res_t want;

  int  fail_count   = 0;
  int  words_sent   = 0;
  int  results_seen = 0;
  int  code_tally [4];
  int  cycles       = 0;
  int  stall_left   = 0;
  int  stall_roll;
  bit  calm         = 1'b0;

  dir_row_t dir_tab [DirRows] = '{
    {KindTick,  BtnS, 1'b1, EvNone,  1'b0, 1'b0, 3'd0},
    {KindPress, BtnF, 1'b0, 7'd0},
    {KindPress, BtnF, 1'b0, 7'd0},
    {KindPress, BtnO, 1'b0, 7'd0},
    {KindPress, BtnS, 1'b1, EvCryo,  1'b0, 1'b1, 3'd0},
    {KindPress, BtnO, 1'b0, 7'd0},
    {KindPress, BtnS, 1'b0, 7'd0},
    {KindPress, BtnF, 1'b0, 7'd0},
    {KindPress, BtnU, 1'b0, 7'd0},
    {KindPress, BtnO, 1'b1, EvGod,   1'b1, 1'b1, 3'd0},
    {KindPress, BtnU, 1'b0, 7'd0},
    {KindPress, BtnU, 1'b0, 7'd0},
    {KindPress, BtnF, 1'b0, 7'd0},
    {KindPress, BtnS, 1'b0, 7'd0},
    {KindPress, BtnO, 1'b0, 7'd0},
    {KindPress, BtnF, 1'b1, EvChaos, 1'b1, 1'b1, 3'd0},
    {KindPress, BtnS, 1'b0, 7'd0},
    {KindPress, BtnS, 1'b0, 7'd0},
    {KindPress, BtnS, 1'b0, 7'd0},
    {KindPress, BtnS, 1'b0, 7'd0},
    {KindPress, BtnS, 1'b0, 7'd0},
    {KindPress, BtnS, 1'b1, EvNone,  1'b1, 1'b1, 3'd6},
    {KindPress, BtnS, 1'b1, EvNone,  1'b1, 1'b1, 3'd0},
    {KindPress, BtnU, 1'b0, 7'd0},
    {KindTick,  BtnF, 1'b0, 7'd0}
  };

  button_code_sequence_detector DUT (.*);

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic res_t predict_status(input logic k, input logic [1:0] b);
    event_e ev;
    res_t   r;
    ev = EvNone;
    if (k == KindPress) begin
      if (sym_cnt >= SeqDepthDefault) begin
        sym_cnt = '0;
      end else begin
        sym_store[sym_cnt] = b;
        sym_cnt = sym_cnt + 1'b1;
        idle_ms = '0;
        if (sym_cnt == GodLen && {sym_store[0], sym_store[1], sym_store[2], sym_store[3],
            sym_store[4]} == {BtnO, BtnS, BtnF, BtnU, BtnO}) begin
          sym_cnt = '0;
          god_flag = 1'b1;
          ev = EvGod;
        end else if (sym_cnt == ChaosLen && {sym_store[0], sym_store[1], sym_store[2],
            sym_store[3], sym_store[4], sym_store[5]} == {BtnU, BtnU, BtnF, BtnS, BtnO, BtnF})
            begin
          sym_cnt = '0;
          ev = EvChaos;
        end else if (sym_cnt == CryoLen && {sym_store[0], sym_store[1], sym_store[2],
            sym_store[3]} == {BtnF, BtnF, BtnO, BtnS}) begin
          sym_cnt = '0;
          lock_left = lock_cfg;
          ev = EvCryo;
        end else if (sym_cnt > LongestCode) begin
          sym_cnt = '0;
        end
      end
    end else begin
      if (idle_ms != IdleMax) idle_ms = idle_ms + 1'b1;
      if (sym_cnt != 0 && idle_ms > {1'b0, timeout_cfg}) sym_cnt = '0;
      if (lock_left != 0) lock_left = lock_left - 1'b1;
    end
    r.event_res   = ev;
    r.god_active  = god_flag;
    r.lock_active = (lock_left != 0);
    r.seq_count   = sym_cnt;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int tick_run();
    if (timeout_cfg <= 64 && $urandom_range(0, 99) < 8)
      return int'(timeout_cfg) + int'($urandom_range(0, 2));
    return $urandom_range(0, 2);
  endfunction

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("%s", msg);
  endtask

  task automatic send_word(input logic k, input logic [1:0] b, input logic typed,
                           input res_t want_in);
    int   gap;
    res_t r;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    button_i   <= b;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_status(k, b);
    status_q.push_back(typed ? want_in : r);
    words_sent++;
  endtask

  task automatic send_rand(input logic k, input logic [1:0] b);
    send_word(k, b, 1'b0, '0);
  endtask

  task automatic tick_burst(input int n);
    logic [1:0] b;
    repeat (n) begin
      b = 2'($urandom_range(0, 3));
      send_rand(KindTick, b);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic clear_store();
    logic [1:0] b;
    while (sym_cnt != 0) begin
      b = 2'($urandom_range(0, 3));
      send_rand(KindPress, b);
    end
  endtask

  task automatic send_code(input event_e which);
    logic [1:0] syms [$];
    int         roll;
    case (which)
      EvGod:   syms = '{BtnO, BtnS, BtnF, BtnU, BtnO};
      EvChaos: syms = '{BtnU, BtnU, BtnF, BtnS, BtnO, BtnF};
      default: syms = '{BtnF, BtnF, BtnO, BtnS};
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 12) syms[$urandom_range(0, syms.size() - 1)] = 2'($urandom_range(0, 3));
    else if (roll < 20) void'(syms.pop_back());
    foreach (syms[i]) begin
      tick_burst(tick_run());
      send_rand(KindPress, syms[i]);
    end
  endtask

  task automatic play_round();
    int         roll;
    logic       k;
    logic [1:0] b;
    event_e     which;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      drain();
    end else if (roll < 68) begin
      clear_store();
      which = event_e'($urandom_range(1, 3));
      send_code(which);
    end else if (roll < 88) begin
      repeat ($urandom_range(1, 8)) begin
        k = 1'($urandom_range(0, 1));
        b = 2'($urandom_range(0, 3));
        send_rand(k, b);
      end
    end else begin
      tick_burst(timeout_cfg <= 64 ? $urandom_range(0, 2 * timeout_cfg + 2)
                                   : $urandom_range(0, 6));
    end
  endtask

  task automatic run_random(input int n);
    int start;
    start = words_sent;
    while (words_sent - start < n) play_round();
  endtask

  task automatic apb_write(input logic [CfgAddrW-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgW-1:0] value);
    logic [31:0] data;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (data !== {16'h0, value})
      report($sformatf("register at 0x%0h: expected 0x%08h, read 0x%08h", addr,
                       {16'h0, value}, data));
  endtask

  task automatic set_limits(input logic [CfgW-1:0] t, input logic [CfgW-1:0] l);
    drain();
    apb_write(AddrTimeout, {16'h0, t});
    timeout_cfg = t;
    apb_write(AddrLock, {16'h0, l});
    lock_cfg = l;
    check_reg(AddrTimeout, t);
    check_reg(AddrLock, l);
  endtask

  always @(negedge clk_i) begin
    if (calm || !rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 65) begin
        out_stall_i <= 1'b0;
      end else if (stall_roll < 95) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.event_res   = event_e'(event_res_o);
      got.god_active  = god_active_o;
      got.lock_active = lock_active_o;
      got.seq_count   = seq_count_o;
      if (status_q.size() == 0) begin
        report($sformatf("unexpected result ev=%0d god=%0b lock=%0b cnt=%0d",
                         got.event_res, got.god_active, got.lock_active, got.seq_count));
      end else begin
        want = status_q.pop_front();
        results_seen++;
        code_tally[want.event_res]++;
        if (got.event_res !== want.event_res || got.god_active !== want.god_active ||
            got.lock_active !== want.lock_active || got.seq_count !== want.seq_count)
          report($sformatf({"result %0d: expected ev=%0d god=%0b lock=%0b cnt=%0d, ",
                            "got ev=%0d god=%0b lock=%0b cnt=%0d"},
                           results_seen, want.event_res, want.god_active, want.lock_active,
                           want.seq_count, got.event_res, got.god_active, got.lock_active,
                           got.seq_count));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               status_q.size());
      $display("** button_code_sequence_detector: FAILED **");
      $finish;
    end
  end

  initial begin
    foreach (sym_store[i]) sym_store[i] = '0;
    foreach (code_tally[i]) code_tally[i] = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_reg(AddrTimeout, TimeoutReset);
    check_reg(AddrLock, LockReset);

    foreach (dir_tab[i]) send_word(dir_tab[i].kind, dir_tab[i].btn, dir_tab[i].typed,
                                   dir_tab[i].want);
    run_random(150);

    set_limits(16'd0, 16'd0);
    run_random(170);
    set_limits(16'd1, 16'd1);
    calm = 1'b1;
    run_random(150);
    calm = 1'b0;
    set_limits(16'd5, 16'd20);
    run_random(180);

    set_limits(16'hFFFF, 16'hFFFF);
    calm = 1'b1;
    clear_store();
    send_code(EvCryo);
    send_rand(KindPress, BtnO);
    tick_burst(LongBurst);
    calm = 1'b0;

    set_limits(16'd40, 16'd200);
    run_random(180);
    set_limits(16'd2, 16'd3);
    run_random(170);
    set_limits(16'($urandom_range(1, 64)), 16'($urandom_range(1, 400)));
    run_random(200);

    drain();
    repeat (8) @(posedge clk_i);
    if (status_q.size() != 0) report("results still outstanding at the end of the run");

    $display("Run covered %0d words under eight limit settings, zero and full scale included.",
             words_sent);
    $display("Checked %0d results; codes recognized: god mode %0d, chaos %0d, cryo %0d.",
             results_seen, code_tally[EvGod], code_tally[EvChaos], code_tally[EvCryo]);
    if (fail_count == 0) begin
      $display("** button_code_sequence_detector: PASSED **");
    end else begin
      $display("** button_code_sequence_detector: FAILED **");
    end
    $finish;
  end

endmodule
